### rtl/trd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and constants for the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
package trd_pkg;

  // Header layout (byte offsets within the 18-byte TGA header)
  localparam int unsigned HdrLen = 18;
  localparam int unsigned HdrIdxW = $clog2(HdrLen);

  localparam logic [HdrIdxW-1:0] HDR_ID_LEN    = HdrIdxW'(0);
  localparam logic [HdrIdxW-1:0] HDR_CMAP_LO   = HdrIdxW'(5);
  localparam logic [HdrIdxW-1:0] HDR_CMAP_HI   = HdrIdxW'(6);
  localparam logic [HdrIdxW-1:0] HDR_CMAP_BITS = HdrIdxW'(7);
  localparam logic [HdrIdxW-1:0] HDR_WIDTH_LO  = HdrIdxW'(12);
  localparam logic [HdrIdxW-1:0] HDR_WIDTH_HI  = HdrIdxW'(13);
  localparam logic [HdrIdxW-1:0] HDR_HEIGHT_LO = HdrIdxW'(14);
  localparam logic [HdrIdxW-1:0] HDR_HEIGHT_HI = HdrIdxW'(15);
  // First byte after width and height are complete: pixel count is formed here
  localparam logic [HdrIdxW-1:0] HDR_AREA      = HdrIdxW'(16);
  localparam logic [HdrIdxW-1:0] HDR_LAST      = HdrIdxW'(HdrLen - 1);

  // ID plus color-map skip saturates at this value
  localparam int unsigned SkipW = 18;
  localparam logic [SkipW-1:0] SKIP_MAX = '1;

  // Packet header byte
  localparam int unsigned RunFlagBit = 7;
  localparam logic [6:0] PKT_COUNT_MASK = 7'h7f;

  // Pixel byte order within a pixel: blue, green, red, alpha
  localparam logic [1:0] PIX_BLUE  = 2'd0;
  localparam logic [1:0] PIX_GREEN = 2'd1;
  localparam logic [1:0] PIX_RED   = 2'd2;
  localparam logic [1:0] PIX_ALPHA = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SKIP   = 2'd1,
    PH_PACKET = 2'd2,
    PH_PIXEL  = 2'd3
  } trd_phase_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  repeat_count;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        last_of_image;
  } trd_result_t;

endpackage
`default_nettype wire

### rtl/trd_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trd_in_stage
// Input register: holds one byte until the decoder takes it.
// ----------------------------------------------------------------------------
module trd_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       advance,
  output logic            byte_valid,
  output logic [7:0]      byte_data
);

  logic       held;
  logic [7:0] held_byte;

  // Full and not draining this cycle
  assign in_stall   = held && !advance;
  assign byte_valid = held;
  assign byte_data  = held_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!in_stall) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      held_byte <= data_byte;
    end
  end

endmodule
`default_nettype wire

### rtl/trd_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trd_decode
// Header parse, ID/color-map skip and RLE packet decode, one byte per cycle.
// ----------------------------------------------------------------------------
module trd_decode
  import trd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_fire,
  input  wire logic [7:0] byte_data,
  output logic            res_fire,
  output trd_result_t     res
);

  trd_phase_t          phase, phase_next;
  logic [HdrIdxW-1:0]  hdr_idx, hdr_idx_next;
  logic [7:0]          id_length, id_length_next;
  logic [15:0]         cmap_len, cmap_len_next;
  logic [7:0]          cmap_bits, cmap_bits_next;
  logic [15:0]         width_reg, width_reg_next;
  logic [15:0]         height_reg, height_reg_next;
  logic [31:0]         total_pix, total_pix_next;
  logic [SkipW-1:0]    skip_remaining, skip_remaining_next;
  logic [7:0]          packet_remaining, packet_remaining_next;
  logic                packet_is_run, packet_is_run_next;
  logic [7:0]          pix_blue, pix_blue_next;
  logic [7:0]          pix_green, pix_green_next;
  logic [7:0]          pix_red, pix_red_next;
  logic [1:0]          pix_idx, pix_idx_next;
  logic [31:0]         pixels_left, pixels_left_next;

  // Color-map skip arithmetic
  logic [8:0]  entry_bits_rnd;
  logic [5:0]  entry_bytes;
  logic [21:0] cmap_bytes;
  logic [22:0] skip_sum;
  logic [SkipW-1:0] skip_sat;

  // Pixel emit arithmetic
  logic [7:0]  count;
  logic [31:0] left_after;
  logic        last;
  logic [7:0]  pr_after;

  assign entry_bits_rnd = {1'b0, cmap_bits} + 9'd7;
  assign entry_bytes    = entry_bits_rnd[8:3];
  assign cmap_bytes     = 22'(cmap_len) * 22'(entry_bytes);
  assign skip_sum       = {1'b0, cmap_bytes} + {15'd0, id_length};
  assign skip_sat       = (skip_sum > {5'd0, SKIP_MAX}) ? SKIP_MAX : skip_sum[SkipW-1:0];

  always_comb begin
    if (packet_is_run) begin
      count = (pixels_left < {24'd0, packet_remaining}) ? pixels_left[7:0]
                                                        : packet_remaining;
      pr_after = 8'd0;
    end else begin
      count = 8'd1;
      pr_after = (packet_remaining != 8'd0) ? packet_remaining - 8'd1 : 8'd0;
    end
  end

  assign left_after = pixels_left - {24'd0, count};
  assign last       = (left_after == 32'd0);

  always_comb begin
    phase_next            = phase;
    hdr_idx_next          = hdr_idx;
    id_length_next        = id_length;
    cmap_len_next         = cmap_len;
    cmap_bits_next        = cmap_bits;
    width_reg_next        = width_reg;
    height_reg_next       = height_reg;
    total_pix_next        = total_pix;
    skip_remaining_next   = skip_remaining;
    packet_remaining_next = packet_remaining;
    packet_is_run_next    = packet_is_run;
    pix_blue_next         = pix_blue;
    pix_green_next        = pix_green;
    pix_red_next          = pix_red;
    pix_idx_next          = pix_idx;
    pixels_left_next      = pixels_left;
    res_fire              = 1'b0;

    res.red           = pix_red;
    res.green         = pix_green;
    res.blue          = pix_blue;
    res.repeat_count  = count;
    res.image_width   = width_reg;
    res.image_height  = height_reg;
    res.last_of_image = last;

    if (byte_fire) begin
      case (phase)
        PH_HEADER: begin
          case (hdr_idx)
            HDR_ID_LEN:    id_length_next      = byte_data;
            HDR_CMAP_LO:   cmap_len_next[7:0]  = byte_data;
            HDR_CMAP_HI:   cmap_len_next[15:8] = byte_data;
            HDR_CMAP_BITS: cmap_bits_next      = byte_data;
            HDR_WIDTH_LO:  width_reg_next[7:0]  = byte_data;
            HDR_WIDTH_HI:  width_reg_next[15:8] = byte_data;
            HDR_HEIGHT_LO: height_reg_next[7:0]  = byte_data;
            HDR_HEIGHT_HI: height_reg_next[15:8] = byte_data;
            HDR_AREA:      total_pix_next = 32'(width_reg) * 32'(height_reg);
            default: ;
          endcase
          if (hdr_idx == HDR_LAST) begin
            hdr_idx_next        = '0;
            skip_remaining_next = skip_sat;
            if (skip_sat != '0) begin
              phase_next = PH_SKIP;
            end else begin
              pixels_left_next = total_pix;
              phase_next = (total_pix == 32'd0) ? PH_HEADER : PH_PACKET;
            end
          end else begin
            hdr_idx_next = hdr_idx + HdrIdxW'(1);
          end
        end
        PH_SKIP: begin
          skip_remaining_next = skip_remaining - SkipW'(1);
          if (skip_remaining == SkipW'(1)) begin
            pixels_left_next = total_pix;
            phase_next = (total_pix == 32'd0) ? PH_HEADER : PH_PACKET;
          end
        end
        PH_PACKET: begin
          packet_is_run_next    = byte_data[RunFlagBit];
          packet_remaining_next = {1'b0, byte_data[6:0] & PKT_COUNT_MASK} + 8'd1;
          pix_idx_next          = PIX_BLUE;
          phase_next            = PH_PIXEL;
        end
        PH_PIXEL: begin
          case (pix_idx)
            PIX_BLUE:  pix_blue_next  = byte_data;
            PIX_GREEN: pix_green_next = byte_data;
            PIX_RED:   pix_red_next   = byte_data;
            default: ;
          endcase
          if (pix_idx == PIX_ALPHA) begin
            res_fire              = 1'b1;
            pixels_left_next      = left_after;
            packet_remaining_next = pr_after;
            pix_idx_next          = PIX_BLUE;
            if (last) begin
              phase_next            = PH_HEADER;
              hdr_idx_next          = '0;
              packet_remaining_next = 8'd0;
            end else if (pr_after == 8'd0) begin
              phase_next = PH_PACKET;
            end
          end else begin
            pix_idx_next = pix_idx + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      hdr_idx          <= '0;
      skip_remaining   <= '0;
      packet_remaining <= 8'd0;
      packet_is_run    <= 1'b0;
      pix_idx          <= PIX_BLUE;
      pixels_left      <= 32'd0;
    end else begin
      phase            <= phase_next;
      hdr_idx          <= hdr_idx_next;
      skip_remaining   <= skip_remaining_next;
      packet_remaining <= packet_remaining_next;
      packet_is_run    <= packet_is_run_next;
      pix_idx          <= pix_idx_next;
      pixels_left      <= pixels_left_next;
    end
  end

  // Header fields and pixel channels
  always_ff @(posedge clk) begin
    id_length  <= id_length_next;
    cmap_len   <= cmap_len_next;
    cmap_bits  <= cmap_bits_next;
    width_reg  <= width_reg_next;
    height_reg <= height_reg_next;
    total_pix  <= total_pix_next;
    pix_blue   <= pix_blue_next;
    pix_green  <= pix_green_next;
    pix_red    <= pix_red_next;
  end

`ifndef SYNTHESIS
  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> skip_remaining != '0)
    else $error("skip phase with nothing left to skip");

  a_pixels_left: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PIXEL |-> pixels_left != 32'd0)
    else $error("pixel phase with no pixels left in image");

  a_packet_open: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PIXEL |-> packet_remaining != 8'd0)
    else $error("pixel phase with empty packet");

  a_last_restart: assert property (@(posedge clk) disable iff (rst)
    res_fire && res.last_of_image |=> phase == PH_HEADER && hdr_idx == '0)
    else $error("decoder did not restart header after last pixel");
`endif

endmodule
`default_nettype wire

### rtl/trd_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trd_out_stage
// Result register: holds one decoded pixel item until the receiver takes it.
// ----------------------------------------------------------------------------
module trd_out_stage
  import trd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         res_fire,
  input  wire trd_result_t  res,
  output logic              advance,
  output logic              out_valid,
  input  wire logic         out_stall,
  output trd_result_t       res_q
);

  // Register is free, or its item leaves at this edge
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_fire) begin
      res_q <= res;
    end
  end

endmodule
`default_nettype wire

### rtl/tga_rle_pixel_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_unit
// Streaming decoder for run-length coded 32-bit BGRA TGA images.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall / data_byte) carries the file stream,
//    one byte per item. The 18-byte header is parsed, then the ID field and
//    color map (entries x whole bytes per entry) are dropped, then RLE
//    packets are decoded.
//  - Output channel (out_valid / out_stall / pixel fields) carries one item
//    per run packet (color + repeat count, clipped to the pixels left) and
//    one item per raw pixel (count 1). Alpha is dropped. last_of_image marks
//    the item that completes the image; the next byte starts a new header.
//  - Throughput: one byte per cycle, sustained while no waiting result is
//    stalled. Every byte goes through a single decode step between the
//    input register and the result register: the item that an alpha byte
//    completes is registered there and drives out_valid.
//  - Stall: while out_stall holds a waiting result, the decoder freezes and
//    in_stall rises once the input register is full.
//  - Reset (rst, synchronous): both channels empty, decoder waits for a
//    header. No clearing pass.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_unit
  import trd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic [7:0]       repeat_count,
  output logic [15:0]      image_width,
  output logic [15:0]      image_height,
  output logic             last_of_image
);

  logic        advance;     // decode step may run this cycle
  logic        byte_valid;  // input register holds a byte
  logic [7:0]  byte_data;
  logic        res_fire;    // decode step produces a pixel item
  trd_result_t res;
  trd_result_t res_q;

  trd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  // Byte is consumed only when the result register can take any output
  trd_decode u_dec (
    .clk       (clk),
    .rst       (rst),
    .byte_fire (byte_valid && advance),
    .byte_data (byte_data),
    .res_fire  (res_fire),
    .res       (res)
  );

  trd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_fire  (res_fire),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_q     (res_q)
  );

  assign red           = res_q.red;
  assign green         = res_q.green;
  assign blue          = res_q.blue;
  assign repeat_count  = res_q.repeat_count;
  assign image_width   = res_q.image_width;
  assign image_height  = res_q.image_height;
  assign last_of_image = res_q.last_of_image;

endmodule
`default_nettype wire

### tb/sv/tga_rle_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_checker
// Watches both channels of the TGA RLE decoder. It follows the byte stream
// with its own decoder state, queues the pixel items that each accepted byte
// should produce, and compares every accepted output item against the oldest
// queued one.
// ----------------------------------------------------------------------------
module tga_rle_pixel_checker
  import trd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  repeat_count,
  input  logic [15:0] image_width,
  input  logic [15:0] image_height,
  input  logic        last_of_image,
  output int          fail_count,
  output int          pending
);

  // Decoder state as seen from the byte stream
  trd_phase_t          phase;
  logic [HdrIdxW-1:0]  hdr_idx;
  logic [7:0]          id_len;
  logic [15:0]         cmap_len;
  logic [7:0]          cmap_bits;
  logic [15:0]         width_q;
  logic [15:0]         height_q;
  logic [SkipW-1:0]    skip_left;
  logic [7:0]          pkt_left;
  logic                pkt_run;
  logic [23:0]         pix_acc;
  logic [1:0]          pix_idx;
  logic [31:0]         pix_done;

  trd_result_t pixel_q[$];

  function automatic logic [31:0] image_area();
    return 32'(width_q) * 32'(height_q);
  endfunction

  // Empty images go straight back to header parsing
  task automatic open_image();
    pix_done = '0;
    if (image_area() == 0) begin
      phase   = PH_HEADER;
      hdr_idx = '0;
    end else begin
      phase = PH_PACKET;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [31:0] skip;
    logic [31:0] area;
    logic [31:0] left;
    logic [31:0] count;
    logic [5:0]  per_entry;
    trd_result_t r;
    case (phase)
      PH_HEADER: begin
        case (hdr_idx)
          HDR_ID_LEN:    id_len = b;
          HDR_CMAP_LO:   cmap_len[7:0] = b;
          HDR_CMAP_HI:   cmap_len[15:8] = b;
          HDR_CMAP_BITS: cmap_bits = b;
          HDR_WIDTH_LO:  width_q[7:0] = b;
          HDR_WIDTH_HI:  width_q[15:8] = b;
          HDR_HEIGHT_LO: height_q[7:0] = b;
          HDR_HEIGHT_HI: height_q[15:8] = b;
          default: ;
        endcase
        if (hdr_idx == HDR_LAST) begin
          per_entry = 6'(({1'b0, cmap_bits} + 9'd7) >> 3);
          skip = 32'(id_len) + 32'(cmap_len) * 32'(per_entry);
          if (skip > 32'(SKIP_MAX)) skip = 32'(SKIP_MAX);
          skip_left = skip[SkipW-1:0];
          hdr_idx = '0;
          if (skip != 0) phase = PH_SKIP;
          else open_image();
        end else begin
          hdr_idx = hdr_idx + 1'b1;
        end
      end
      PH_SKIP: begin
        if (skip_left != 0) skip_left = skip_left - 1'b1;
        if (skip_left == 0) open_image();
      end
      PH_PACKET: begin
        pkt_run  = b[RunFlagBit];
        pkt_left = {1'b0, b[6:0] & PKT_COUNT_MASK} + 8'd1;
        pix_idx  = PIX_BLUE;
        pix_acc  = '0;
        phase    = PH_PIXEL;
      end
      default: begin
        if (pix_idx != PIX_ALPHA) begin
          pix_acc = pix_acc | (24'(b) << (8 * pix_idx));
          pix_idx = pix_idx + 1'b1;
        end else begin
          // alpha byte closes the pixel; runs are clipped to what is left
          area = image_area();
          left = (area > pix_done) ? area - pix_done : '0;
          if (pkt_run) begin
            count = (32'(pkt_left) > left) ? left : 32'(pkt_left);
            pkt_left = '0;
          end else begin
            count = 32'd1;
            if (pkt_left != 0) pkt_left = pkt_left - 1'b1;
          end
          pix_done = pix_done + count;
          r.red           = pix_acc[23:16];
          r.green         = pix_acc[15:8];
          r.blue          = pix_acc[7:0];
          r.repeat_count  = count[7:0];
          r.image_width   = width_q;
          r.image_height  = height_q;
          r.last_of_image = (pix_done >= area);
          pixel_q.push_back(r);
          pix_acc = '0;
          pix_idx = PIX_BLUE;
          if (r.last_of_image) begin
            phase    = PH_HEADER;
            hdr_idx  = '0;
            pkt_left = '0;
          end else if (pkt_left == 0) begin
            phase = PH_PACKET;
          end
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    trd_result_t want;
    if (rst) begin
      phase     = PH_HEADER;
      hdr_idx   = '0;
      id_len    = '0;
      cmap_len  = '0;
      cmap_bits = '0;
      width_q   = '0;
      height_q  = '0;
      skip_left = '0;
      pkt_left  = '0;
      pkt_run   = 1'b0;
      pix_acc   = '0;
      pix_idx   = PIX_BLUE;
      pix_done  = '0;
      pixel_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel item: red %0d green %0d blue %0d count %0d",
                 red, green, blue, repeat_count);
          fail_count++;
        end else begin
          want = pixel_q.pop_front();
          check_field("red", 32'(want.red), 32'(red));
          check_field("green", 32'(want.green), 32'(green));
          check_field("blue", 32'(want.blue), 32'(blue));
          check_field("repeat_count", 32'(want.repeat_count), 32'(repeat_count));
          check_field("image_width", 32'(want.image_width), 32'(image_width));
          check_field("image_height", 32'(want.image_height), 32'(image_height));
          check_field("last_of_image", 32'(want.last_of_image), 32'(last_of_image));
        end
      end
      if (in_valid && !in_stall) decode_byte(data_byte);
    end
    pending = pixel_q.size();
  end

endmodule

### tb/sv/tb_tga_rle_pixel_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tga_rle_pixel_decoder_unit
// Feeds the TGA RLE decoder whole image streams (header, ID and color-map
// skip, run and raw packets) with random idle gaps and output stalls. The
// checker beside the block predicts and compares; this top only builds the
// byte stream, drives the handshakes and reports the verdict.
// ----------------------------------------------------------------------------
module tb_tga_rle_pixel_decoder_unit;
  import trd_pkg::*;

  // How the packets of one image are shaped
  typedef enum int {PKT_RAW, PKT_RUN, PKT_MIX} pkt_mix_t;

  localparam int ResultsPerChoke = 100;  // long output hold every so many items
  localparam int ChokeCycles     = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  repeat_count;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        last_of_image;

  int fail_count;
  int pending;

  // Sender and receiver gap control
  bit tx_burst = 1'b0;      // sender offers back to back
  bit rx_burst = 1'b0;      // receiver takes back to back
  int choke_left = 0;       // cycles left in a long receiver hold
  int sent_bytes = 0;       // bytes accepted so far, skip bytes included

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  tga_rle_pixel_decoder_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .repeat_count  (repeat_count),
    .image_width   (image_width),
    .image_height  (image_height),
    .last_of_image (last_of_image)
  );

  tga_rle_pixel_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .repeat_count  (repeat_count),
    .image_width   (image_width),
    .image_height  (image_height),
    .last_of_image (last_of_image),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // Called at a falling edge; returns at the falling edge after acceptance.
  // valid drops only when a gap is drawn, so back-to-back items keep it high.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (tx_burst || choke_left > 0) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    sent_bytes++;
    @(negedge clk);
  endtask

  // One complete image: 18-byte header with random filler in the ignored
  // fields, the ID/color-map bytes to be dropped, then packets until the
  // image is full or max_packets is used up.
  task automatic send_image(input logic [7:0] id_len, input logic [15:0] cmap_len,
                            input logic [7:0] cmap_bits, input logic [15:0] w,
                            input logic [15:0] h, input pkt_mix_t mix,
                            input int pkt_len, input int pix_fill,
                            input int max_packets);
    logic [7:0] hdr [HdrLen];
    longint skip;
    longint left;
    longint npix;
    int n;
    int k;
    bit run;
    bit saved_burst;
    for (k = 0; k < HdrLen; k++) hdr[k] = 8'($urandom_range(0, 255));
    hdr[HDR_ID_LEN]    = id_len;
    hdr[HDR_CMAP_LO]   = cmap_len[7:0];
    hdr[HDR_CMAP_HI]   = cmap_len[15:8];
    hdr[HDR_CMAP_BITS] = cmap_bits;
    hdr[HDR_WIDTH_LO]  = w[7:0];
    hdr[HDR_WIDTH_HI]  = w[15:8];
    hdr[HDR_HEIGHT_LO] = h[7:0];
    hdr[HDR_HEIGHT_HI] = h[15:8];
    for (k = 0; k < HdrLen; k++) send_byte(hdr[k]);

    // map entries are whole bytes; the whole skip saturates
    skip = longint'(id_len) + longint'(cmap_len) * ((longint'(cmap_bits) + 7) / 8);
    if (skip > longint'(SKIP_MAX)) skip = longint'(SKIP_MAX);
    saved_burst = tx_burst;
    if (skip > 1000) tx_burst = 1'b1;  // keep a long skip short in time
    repeat (skip) send_byte(8'($urandom_range(0, 255)));
    tx_burst = saved_burst;

    left = longint'(w) * longint'(h);
    while (left > 0 && max_packets > 0) begin
      max_packets--;
      case (mix)
        PKT_RAW: run = 1'b0;
        PKT_RUN: run = 1'b1;
        default: run = $urandom_range(0, 1);
      endcase
      if (pkt_len > 0) n = pkt_len;
      else if ($urandom_range(0, 4) == 0) n = $urandom_range(1, 128);
      else n = $urandom_range(1, 6);
      send_byte({run, 7'(n - 1)});
      // a raw packet past the image end stops at the last pixel
      npix = run ? 1 : ((longint'(n) > left) ? left : longint'(n));
      left -= (longint'(n) > left) ? left : longint'(n);
      repeat (npix) begin
        repeat (4) begin
          send_byte((pix_fill < 0) ? 8'($urandom_range(0, 255)) : 8'(pix_fill));
        end
      end
    end
  endtask

  // Receiver: a random hold before each item, back-to-back stretches, and
  // now and then a long hold so the block backs up into in_stall.
  initial begin : result_sink
    int hold;
    int taken;
    hold  = 0;
    taken = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        taken++;
        if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
        if (taken % ResultsPerChoke == 10) choke_left = ChokeCycles;
        hold = rx_burst ? 0 : $urandom_range(0, 15);
      end
      @(negedge clk);
      if (choke_left > 0) begin
        out_stall <= 1'b1;
        choke_left--;
      end else if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed images
    // single pixel, run of one, all-zero color
    send_image(8'd0, 16'd0, 8'd0, 16'd1, 16'd1, PKT_RUN, 1, 8'h00, 1 << 30);
    // raw packet of 128 in a 6-pixel image: ends at the last pixel
    send_image(8'd0, 16'd0, 8'd0, 16'd2, 16'd3, PKT_RAW, 128, 8'hff, 1 << 30);
    // empty images, one with an ID field to skip
    send_image(8'd4, 16'd0, 8'd0, 16'd0, 16'd5, PKT_MIX, 0, -1, 1 << 30);
    send_image(8'd0, 16'd0, 8'd0, 16'd7, 16'd0, PKT_MIX, 0, -1, 1 << 30);
    // ID plus 2 entries of 15 bits, run of 128 clipped to 3 pixels
    send_image(8'd3, 16'd2, 8'd15, 16'd3, 16'd1, PKT_RUN, 128, -1, 1 << 30);
    // widest entry size rounds to 32 bytes; one-bit entries to 1 byte
    send_image(8'd0, 16'd1, 8'd255, 16'd2, 16'd2, PKT_MIX, 0, -1, 1 << 30);
    send_image(8'd0, 16'd3, 8'd1, 16'd1, 16'd3, PKT_MIX, 0, -1, 1 << 30);

    // Random images: mostly small and well formed, some empty or with skips
    while (sent_bytes < 650) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      send_image(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 12)) : 8'd0,
                 ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 4)) : 16'd0,
                 8'($urandom_range(0, 255)),
                 ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 6)),
                 ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 6)),
                 PKT_MIX, 0, -1, 1 << 30);
    end
    tx_burst = 1'b0;

    // largest image, left unfinished after two short packets
    send_image(8'd0, 16'd0, 8'd0, 16'hffff, 16'hffff, PKT_MIX, 4, -1, 2);

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
rtl/trd_pkg.sv
rtl/trd_in_stage.sv
rtl/trd_decode.sv
rtl/trd_out_stage.sv
rtl/tga_rle_pixel_decoder_unit.sv
tb/sv/tga_rle_pixel_checker.sv
tb/sv/tb_tga_rle_pixel_decoder_unit.sv
